// ----- rtl/core/acsm_pkg.sv -----
// Shared types and constants of the ADC channel scan median filter.
`timescale 1ns / 1ps
package acsm_pkg;

  localparam int unsigned SampleBitsDef  = 12;
  localparam int unsigned KeptSamplesDef = 5;
  localparam int unsigned ChanW          = 4;
  localparam int unsigned SlotW          = 2;
  localparam int unsigned CfgIdxW        = 2;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [SlotW-1:0] slot_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FIRST_CHANNEL  = 2'd0,
    CFG_SECOND_CHANNEL = 2'd1,
    CFG_THIRD_CHANNEL  = 2'd2
  } cfg_idx_e;

  localparam slot_t SlotFirst  = 2'd0;
  localparam slot_t SlotSecond = 2'd1;
  localparam slot_t SlotThird  = 2'd2;

  localparam chan_t FirstChanRst  = 4'd0;
  localparam chan_t SecondChanRst = 4'd1;
  localparam chan_t ThirdChanRst  = 4'd2;

  typedef struct packed {
    logic  emit;
    slot_t slot;
    logic  round_done;
    chan_t next_channel;
  } scan_res_t;

endpackage

// ----- rtl/core/acsm_median.sv -----
// Rank-based median select over one set of kept samples.
`timescale 1ns / 1ps
module acsm_median #(
  parameter int unsigned SampleBits  = acsm_pkg::SampleBitsDef,
  parameter int unsigned KeptSamples = acsm_pkg::KeptSamplesDef
) (
  input  logic [KeptSamples-1:0][SampleBits-1:0] set_i,
  output logic [SampleBits-1:0]                  median_o
);
  import acsm_pkg::*;

  localparam int unsigned RankW   = $clog2(KeptSamples);
  localparam int unsigned MidRank = KeptSamples / 2;

  logic [KeptSamples-1:0][RankW-1:0] rank;

  // Rank each element; equal values are ordered by position, so ranks are unique.
  always_comb begin
    for (int i = 0; i < KeptSamples; i++) begin
      rank[i] = '0;
      for (int j = 0; j < KeptSamples; j++) begin
        if (j != i) begin
          if ((set_i[j] < set_i[i]) || ((set_i[j] == set_i[i]) && (j < i))) begin
            rank[i] = rank[i] + RankW'(1);
          end
        end
      end
    end
  end

  always_comb begin
    median_o = '0;
    for (int i = 0; i < KeptSamples; i++) begin
      if (rank[i] == RankW'(MidRank)) begin
        median_o = set_i[i];
      end
    end
  end

endmodule

// ----- rtl/core/acsm_scan_ctrl.sv -----
// Channel registers, per-channel sample counter, slot sequencer and sample store.
`timescale 1ns / 1ps
module acsm_scan_ctrl #(
  parameter int unsigned SampleBits  = acsm_pkg::SampleBitsDef,
  parameter int unsigned KeptSamples = acsm_pkg::KeptSamplesDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   accept_i,
  input  logic [SampleBits-1:0]                  sample_i,
  input  logic                                   cfg_valid_i,
  input  logic [acsm_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  acsm_pkg::chan_t                        cfg_data_i,
  output acsm_pkg::scan_res_t                    res_o,
  output logic [KeptSamples-1:0][SampleBits-1:0] set_o
);
  import acsm_pkg::*;

  localparam int unsigned CntW = $clog2(KeptSamples + 1);
  localparam logic [CntW-1:0] CntLast = CntW'(KeptSamples);

  chan_t           chan0_q, chan1_q, chan2_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  slot_t           slot_q, slot_d;
  logic            complete;
  chan_t           next_chan;
  logic            round_done;

  logic [SampleBits-1:0] kept_q [KeptSamples-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan0_q <= FirstChanRst;
      chan1_q <= SecondChanRst;
      chan2_q <= ThirdChanRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_FIRST_CHANNEL) begin
        chan0_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_SECOND_CHANNEL) begin
        chan1_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_THIRD_CHANNEL) begin
        chan2_q <= cfg_data_i;
      end
    end
  end

  // A count past the last kept sample also completes the set.
  assign complete = (cnt_q >= CntLast);

  always_comb begin
    unique case (slot_q)
      SlotFirst: begin
        next_chan  = chan1_q;
        round_done = 1'b0;
        slot_d     = SlotSecond;
      end
      SlotSecond: begin
        next_chan  = chan2_q;
        round_done = 1'b0;
        slot_d     = SlotThird;
      end
      default: begin
        next_chan  = chan0_q;
        round_done = 1'b1;
        slot_d     = SlotFirst;
      end
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (accept_i) begin
      cnt_d = complete ? '0 : cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      slot_q <= SlotFirst;
    end else begin
      cnt_q <= cnt_d;
      if (accept_i && complete) begin
        slot_q <= slot_d;
      end
    end
  end

  // Count zero is the settling sample after a switch: store nothing.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < KeptSamples - 1; i++) begin
      if (accept_i && (cnt_q == CntW'(i + 1))) begin
        kept_q[i] <= sample_i;
      end
    end
  end

  for (genvar g = 0; g < KeptSamples - 1; g++) begin : g_set
    assign set_o[g] = kept_q[g];
  end
  assign set_o[KeptSamples-1] = sample_i;

  assign res_o.emit         = accept_i && complete;
  assign res_o.slot         = slot_q;
  assign res_o.round_done   = round_done;
  assign res_o.next_channel = next_chan;

endmodule

// ----- rtl/core/adc_channel_scan_median_core.sv -----
// ADC channel scan median filter: top level with input and result registers.
// The median, one compare layer and a rank select, sits between stage 1 and the output.
// Throughput: one sample per cycle unless a held result stalls stage 1.
// Only the completing sample of each channel occupies the two result stages.
// Reset: asynchronous active low; clears counters, slot, valids and loads the
// default channel codes 0, 1, 2. The sample store is not cleared.
`timescale 1ns / 1ps
module adc_channel_scan_median_core #(
  parameter int unsigned SAMPLE_BITS  = acsm_pkg::SampleBitsDef,
  parameter int unsigned KEPT_SAMPLES = acsm_pkg::KeptSamplesDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [SAMPLE_BITS-1:0]       sample_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output acsm_pkg::slot_t              slot_o,
  output logic [SAMPLE_BITS-1:0]       median_value_o,
  output logic                         round_done_o,
  output acsm_pkg::chan_t              next_channel_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [acsm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  acsm_pkg::chan_t              cfg_data_i
);
  import acsm_pkg::*;

  logic      accept;
  scan_res_t res;
  logic [KEPT_SAMPLES-1:0][SAMPLE_BITS-1:0] set;

  logic      s1_valid_q;
  scan_res_t s1_res_q;
  logic [KEPT_SAMPLES-1:0][SAMPLE_BITS-1:0] s1_set_q;
  logic      s1_adv;
  logic [SAMPLE_BITS-1:0] median;

  logic out_valid_q;

  assign cfg_ready_o = 1'b1;
  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign accept      = in_valid_i && in_ready_o;

  acsm_scan_ctrl #(
    .SampleBits (SAMPLE_BITS),
    .KeptSamples(KEPT_SAMPLES)
  ) u_scan_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .sample_i   (sample_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .res_o      (res),
    .set_o      (set)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (res.emit) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload stages: load only on a completing request or an advance.
  always_ff @(posedge clk_i) begin
    if (res.emit) begin
      s1_res_q <= res;
      s1_set_q <= set;
    end
    if (s1_adv) begin
      slot_o         <= s1_res_q.slot;
      median_value_o <= median;
      round_done_o   <= s1_res_q.round_done;
      next_channel_o <= s1_res_q.next_channel;
    end
  end

  acsm_median #(
    .SampleBits (SAMPLE_BITS),
    .KeptSamples(KEPT_SAMPLES)
  ) u_median (
    .set_i   (s1_set_q),
    .median_o(median)
  );

  assign out_valid_o = out_valid_q;

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the ADC channel scan median filter core.
`timescale 1ns / 1ps
module testbench;
  import acsm_pkg::*;

  localparam int unsigned SampleW     = SampleBitsDef;
  localparam int unsigned KeptN       = KeptSamplesDef;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned RandomItems = 1350;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;

  typedef struct {
    slot_t                slot;
    logic [SampleW-1:0]   median;
    logic                 round_done;
    chan_t                next_ch;
  } scan_out_t;

  typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_TOGGLE} ready_mode_e;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  logic [SampleW-1:0] sample_i    = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  slot_t              slot_o;
  logic [SampleW-1:0] median_value_o;
  logic               round_done_o;
  chan_t              next_channel_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  chan_t              cfg_data_i  = '0;

  // Predictor state: channel codes, kept samples, per-channel count and scan slot.
  chan_t              first_ch  = FirstChanRst;
  chan_t              second_ch = SecondChanRst;
  chan_t              third_ch  = ThirdChanRst;
  logic [SampleW-1:0] kept_q [KeptN];
  int unsigned        taken_cnt = 0;
  slot_t              scan_slot = SlotFirst;

  logic [SampleW-1:0] sample_pend_q [$];
  scan_out_t          expected_scan_q [$];
  int unsigned        mismatch_cnt = 0;

  int unsigned        burst_left = 0;
  int unsigned        gap_left = 0;
  ready_mode_e        ready_mode = READY_ALWAYS;
  int unsigned        mode_left = 0;
  bit                 toggle_q = 1'b0;

  adc_channel_scan_median_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sample_i       (sample_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .slot_o         (slot_o),
    .median_value_o (median_value_o),
    .round_done_o   (round_done_o),
    .next_channel_o (next_channel_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Advance the scan by one accepted sample and queue the filtered value it completes.
  function automatic void take_sample(input logic [SampleW-1:0] value);
    scan_out_t res;
    int        lower;
    int        not_higher;
    int        i;
    int        j;
    if (taken_cnt == 0) begin
      // drop the first sample after a channel switch
      taken_cnt = 1;
      return;
    end
    kept_q[taken_cnt-1] = value;
    if (taken_cnt < KeptN) begin
      taken_cnt++;
      return;
    end
    res.median = '0;
    for (i = 0; i < KeptN; i++) begin
      lower = 0;
      not_higher = 0;
      for (j = 0; j < KeptN; j++) begin
        if (kept_q[j] < kept_q[i]) lower++;
        if (kept_q[j] <= kept_q[i]) not_higher++;
      end
      if (lower <= KeptN / 2 && not_higher > KeptN / 2) res.median = kept_q[i];
    end
    res.slot = scan_slot;
    res.round_done = 1'b0;
    case (scan_slot)
      SlotFirst: begin
        res.next_ch = second_ch;
        scan_slot = SlotSecond;
      end
      SlotSecond: begin
        res.next_ch = third_ch;
        scan_slot = SlotThird;
      end
      default: begin
        res.next_ch = first_ch;
        res.round_done = 1'b1;
        scan_slot = SlotFirst;
      end
    endcase
    taken_cnt = 0;
    expected_scan_q.push_back(res);
  endfunction

  // Sample driver: bursts of requests with random gaps in between.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_i <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) take_sample(sample_i);
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (sample_pend_q.size() > 0) begin
          in_valid_i <= 1'b1;
          sample_i <= sample_pend_q.pop_front();
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted result with the oldest expected one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      mode_left = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_scan_q.size() == 0) begin
          $error("unexpected result: slot %0d median %0d", slot_o, median_value_o);
          mismatch_cnt++;
        end else begin
          scan_out_t exp_res;
          exp_res = expected_scan_q.pop_front();
          if (slot_o !== exp_res.slot) begin
            $error("slot: expected %0d, got %0d", exp_res.slot, slot_o);
            mismatch_cnt++;
          end
          if (median_value_o !== exp_res.median) begin
            $error("median_value: expected %0d, got %0d", exp_res.median, median_value_o);
            mismatch_cnt++;
          end
          if (round_done_o !== exp_res.round_done) begin
            $error("round_done: expected %0d, got %0d", exp_res.round_done, round_done_o);
            mismatch_cnt++;
          end
          if (next_channel_o !== exp_res.next_ch) begin
            $error("next_channel: expected %0d, got %0d", exp_res.next_ch, next_channel_o);
            mismatch_cnt++;
          end
        end
      end
      if (mode_left == 0) begin
        ready_mode = ready_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 120);
      end else begin
        mode_left--;
      end
      toggle_q = ~toggle_q;
      case (ready_mode)
        READY_ALWAYS: out_ready_i <= 1'b1;
        READY_MOSTLY: out_ready_i <= ($urandom_range(0, 3) != 0);
        READY_RARELY: out_ready_i <= ($urandom_range(0, 3) == 0);
        default:      out_ready_i <= toggle_q;
      endcase
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input chan_t value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_FIRST_CHANNEL:  first_ch = value;
      CFG_SECOND_CHANNEL: second_ch = value;
      CFG_THIRD_CHANNEL:  third_ch = value;
      default: ;
    endcase
  endtask

  // Hold until every request is taken and every result has come, then let the pipe settle.
  task automatic wait_drained();
    while (sample_pend_q.size() != 0 || in_valid_i || expected_scan_q.size() != 0)
      @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    int unsigned        random_sent;
    int unsigned        phase_len;
    int unsigned        phase;
    logic [SampleW-1:0] base;
    logic [SampleW-1:0] value;
    random_sent = 0;
    phase = 0;
    base = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Reset channel codes; extremes and bit patterns; a dropped settling sample per channel;
    // duplicates; the last channel is left open across the next register change.
    @(negedge clk_i);
    sample_pend_q = '{12'hFFF, 12'hFFF, 12'hFFF, 12'h000, 12'h000, 12'hFFF,
                      12'h000, 12'hAAA, 12'h555, 12'hFFF, 12'h000, 12'h7FF,
                      12'h123, 12'd9, 12'd9, 12'd9, 12'd1, 12'd1,
                      12'hFFF, 12'h800, 12'h001};
    wait_drained();

    while (random_sent < RandomItems) begin
      case (phase)
        0: begin
          write_reg(CFG_FIRST_CHANNEL, 4'hF);
          write_reg(CFG_SECOND_CHANNEL, 4'hF);
          write_reg(CFG_THIRD_CHANNEL, 4'hF);
          write_reg(CfgIdxUnused, 4'h0);
        end
        1: begin
          write_reg(CFG_FIRST_CHANNEL, 4'h0);
          write_reg(CFG_SECOND_CHANNEL, 4'h0);
          write_reg(CFG_THIRD_CHANNEL, 4'h0);
        end
        2: begin
          write_reg(CFG_THIRD_CHANNEL, 4'hA);
          write_reg(CFG_SECOND_CHANNEL, 4'h5);
          write_reg(CFG_FIRST_CHANNEL, 4'hF);
          write_reg(CfgIdxUnused, 4'hF);
        end
        default: begin
          write_reg(CFG_FIRST_CHANNEL, chan_t'($urandom_range(0, 15)));
          write_reg(CFG_SECOND_CHANNEL, chan_t'($urandom_range(0, 15)));
          write_reg(CFG_THIRD_CHANNEL, chan_t'($urandom_range(0, 15)));
        end
      endcase
      @(negedge clk_i);
      phase_len = $urandom_range(150, 260);
      for (int unsigned k = 0; k < phase_len; k++) begin
        if (k % 6 == 0) base = SampleW'($urandom_range(0, (1 << SampleW) - 4));
        case ($urandom_range(0, 9))
          0:       value = '0;
          1:       value = '1;
          2, 3, 4: value = base + SampleW'($urandom_range(0, 3));
          default: value = SampleW'($urandom_range(0, (1 << SampleW) - 1));
        endcase
        sample_pend_q.push_back(value);
      end
      random_sent += phase_len;
      phase++;
      wait_drained();
    end

    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
